@@ rtl/modbus_rtu_response_checker_macros.svh @@
// Assertion macros for the response checker's assertion file.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MRC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mrc_pkg.sv @@
// Types, codes and the CRC-16 byte update for the Modbus RTU response checker.
// No dependencies.
package mrc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEAD,
		PH_BODY,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FUNC_WRONG  = 3'd1,
		ST_SLAVE_WRONG = 3'd2,
		ST_TOO_LONG    = 3'd3,
		ST_BAD_CRC     = 3'd4,
		ST_EXCEPTION   = 3'd5
	} status_t;

	typedef enum logic {
		CFG_SLAVE_ADDR = 1'b0,
		CFG_EXP_FUNC   = 1'b1
	} cfg_index_t;

	localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
	localparam logic [6:0]  EXP_FUNC_RST   = 7'h03;
	localparam logic [6:0]  FN_READ_HOLD   = 7'h03;
	localparam logic [6:0]  FN_READ_INPUT  = 7'h04;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;

	// header length arithmetic runs on byte count plus overhead
	localparam int TOT_W = 9;
	localparam logic [TOT_W-1:0] EXC_FRAME_LEN   = 9'd5;
	localparam logic [TOT_W-1:0] RD_OVERHEAD     = 9'd5;
	localparam logic [TOT_W-1:0] FIXED_FRAME_LEN = 9'd8;

	// tdata field offsets on the result side
	localparam int PAY_LSB = 0;
	localparam int ST_LSB  = 8;
	localparam int EXC_LSB = 11;
	localparam int LEN_LSB = 19;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		status_t    status;
		logic [7:0] exception_code;
	} res_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/modbus_rtu_response_checker.sv @@
// Modbus RTU response checker: one received byte in per cycle while m_tready is high, at most one result out.
// A byte is held in the input register, and its result is then held in the result register to show on m_tvalid.
// Throughput: one byte per cycle while m_tready is high; the CRC-16 byte update,
// frame decode and length check sit in one stage between input and result registers.
// Reset (arst_n low, asynchronous): parser idle, CRC at 0xFFFF, slave address 1,
// expected function 3, both stream sides empty.
module modbus_rtu_response_checker
	import mrc_pkg::*;
#(
	parameter  int MAX_FRAME = 64,
	localparam int LEN_W     = $clog2(MAX_FRAME + 1),
	localparam int TDATA_W   = ((LEN_LSB + LEN_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // rx_byte
	input  logic               s_tuser,   // first_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // payload_byte, status, exception_code, frame_length
	output logic               m_tuser    // kind
);

	logic             valid_s1;
	logic [7:0]       rx_byte_s1;
	logic             first_s1;
	logic             adv;
	logic             res_valid;
	res_t             res;
	logic [LEN_W-1:0] res_len;

	assign adv = valid_s1 && (!m_tvalid || m_tready);

	mrc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.rx_byte_s1 (rx_byte_s1),
		.first_s1   (first_s1)
	);

	mrc_parser #(.MAX_FRAME(MAX_FRAME)) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (adv),
		.rx_byte    (rx_byte_s1),
		.first_byte (first_s1),
		.res_valid  (res_valid),
		.res        (res),
		.res_len    (res_len)
	);

	mrc_out_stage #(.LEN_W(LEN_W)) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && res_valid),
		.res      (res),
		.res_len  (res_len),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ rtl/mrc_in_stage.sv @@
// Input register of the response checker: holds one received byte and its flag.
// Depends on mrc_pkg.
module mrc_in_stage
	import mrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] rx_byte_s1,
	output logic       first_s1
);

	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata;
			first_s1   <= s_tuser;
		end
	end

endmodule

@@ rtl/mrc_parser.sv @@
// Frame parser: configuration registers, frame state, CRC-16 and result decode.
// Depends on mrc_pkg.
module mrc_parser
	import mrc_pkg::*;
#(
	parameter  int MAX_FRAME = 64,
	localparam int LEN_W     = $clog2(MAX_FRAME + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic             first_byte,
	output logic             res_valid,
	output res_t             res,
	output logic [LEN_W-1:0] res_len
);

	logic [7:0]       slave_addr_q;
	logic [6:0]       exp_func_q;
	phase_t           phase_q, phase_d, phase_e;
	logic [LEN_W-1:0] pos_q, pos_d, pos_e;
	logic [LEN_W-1:0] total_q, total_d, total_e;
	logic [15:0]      crc_q, crc_d, crc_e, crc_upd;
	logic [7:0]       crc_lo_q, crc_lo_d, crc_lo_e;
	logic             exc_q, exc_d, exc_e;
	logic [7:0]       exc_code_q, exc_code_d, exc_code_e;
	logic             slave_bad_q, slave_bad_d, slave_bad_e;
	logic             func_bad_q, func_bad_d, func_bad_e;

	logic             take;
	logic             fn34;
	logic [7:0]       exc_form;
	logic [TOT_W-1:0] head_total;
	status_t          hdr_st;
	logic [LEN_W:0]   pos_p2;
	logic [LEN_W:0]   total_x;
	logic             body_data;
	logic             body_crclo;
	logic             crc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
			exp_func_q   <= EXP_FUNC_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SLAVE_ADDR: slave_addr_q <= cfg_data;
				CFG_EXP_FUNC:   exp_func_q   <= cfg_data[6:0];
				default:        ;
			endcase
		end
	end

	// a first byte restarts all frame state
	assign phase_e     = first_byte ? PH_HEAD : phase_q;
	assign pos_e       = first_byte ? '0 : pos_q;
	assign total_e     = first_byte ? '0 : total_q;
	assign crc_e       = first_byte ? CRC_INIT : crc_q;
	assign crc_lo_e    = first_byte ? 8'h00 : crc_lo_q;
	assign exc_e       = first_byte ? 1'b0 : exc_q;
	assign exc_code_e  = first_byte ? 8'h00 : exc_code_q;
	assign slave_bad_e = first_byte ? 1'b0 : slave_bad_q;
	assign func_bad_e  = first_byte ? 1'b0 : func_bad_q;

	assign take     = step && (first_byte || phase_q == PH_HEAD || phase_q == PH_BODY);
	assign crc_upd  = crc16_byte(crc_e, rx_byte);
	assign fn34     = (exp_func_q == FN_READ_HOLD) || (exp_func_q == FN_READ_INPUT);
	assign exc_form = {1'b1, exp_func_q};

	assign head_total = exc_e ? EXC_FRAME_LEN :
		fn34 ? ({1'b0, rx_byte} + RD_OVERHEAD) : FIXED_FRAME_LEN;

	always_comb begin
		if (func_bad_e) begin
			hdr_st = ST_FUNC_WRONG;
		end else if (slave_bad_e) begin
			hdr_st = ST_SLAVE_WRONG;
		end else if (head_total > TOT_W'(MAX_FRAME)) begin
			hdr_st = ST_TOO_LONG;
		end else begin
			hdr_st = ST_OK;
		end
	end

	assign pos_p2     = {1'b0, pos_e} + (LEN_W + 1)'(2);
	assign total_x    = {1'b0, total_e};
	assign body_data  = pos_p2 < total_x;
	assign body_crclo = pos_p2 == total_x;
	assign crc_ok     = {rx_byte, crc_lo_e} == crc_e;

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		total_d     = total_q;
		crc_d       = crc_q;
		crc_lo_d    = crc_lo_q;
		exc_d       = exc_q;
		exc_code_d  = exc_code_q;
		slave_bad_d = slave_bad_q;
		func_bad_d  = func_bad_q;
		if (take) begin
			phase_d     = phase_e;
			pos_d       = pos_e;
			total_d     = total_e;
			crc_d       = crc_e;
			crc_lo_d    = crc_lo_e;
			exc_d       = exc_e;
			exc_code_d  = exc_code_e;
			slave_bad_d = slave_bad_e;
			func_bad_d  = func_bad_e;
			case (phase_e)
				PH_HEAD: begin
					crc_d = crc_upd;
					if (pos_e == LEN_W'(0)) begin
						slave_bad_d = rx_byte != slave_addr_q;
						pos_d       = LEN_W'(1);
					end else if (pos_e == LEN_W'(1)) begin
						exc_d      = rx_byte == exc_form;
						func_bad_d = (rx_byte != exc_form) && (rx_byte != {1'b0, exp_func_q});
						pos_d      = LEN_W'(2);
					end else begin
						if (exc_e) begin
							exc_code_d = rx_byte;
						end
						if (hdr_st != ST_OK) begin
							phase_d = PH_SKIP;
						end else begin
							total_d = head_total[LEN_W-1:0];
							pos_d   = LEN_W'(3);
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					pos_d = pos_e + LEN_W'(1);
					if (body_data) begin
						crc_d = crc_upd;
					end else if (body_crclo) begin
						crc_lo_d = rx_byte;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		res_len   = '0;
		if (take) begin
			case (phase_e)
				PH_HEAD: begin
					if (pos_e != LEN_W'(0) && pos_e != LEN_W'(1) && hdr_st != ST_OK) begin
						res_valid  = 1'b1;
						res.kind   = 1'b1;
						res.status = hdr_st;
					end
				end
				PH_BODY: begin
					if (body_data) begin
						res_valid        = !exc_e && fn34;
						res.payload_byte = rx_byte;
					end else if (!body_crclo) begin
						res_valid = 1'b1;
						res.kind  = 1'b1;
						if (!crc_ok) begin
							res.status = ST_BAD_CRC;
						end else if (exc_e) begin
							res.status         = ST_EXCEPTION;
							res.exception_code = exc_code_e;
						end else begin
							res.status = ST_OK;
							res_len    = total_e;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			total_q     <= '0;
			crc_q       <= CRC_INIT;
			crc_lo_q    <= 8'h00;
			exc_q       <= 1'b0;
			exc_code_q  <= 8'h00;
			slave_bad_q <= 1'b0;
			func_bad_q  <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			total_q     <= total_d;
			crc_q       <= crc_d;
			crc_lo_q    <= crc_lo_d;
			exc_q       <= exc_d;
			exc_code_q  <= exc_code_d;
			slave_bad_q <= slave_bad_d;
			func_bad_q  <= func_bad_d;
		end
	end

endmodule

@@ rtl/mrc_out_stage.sv @@
// Result register of the response checker: packs one result onto the output stream.
// Depends on mrc_pkg.
module mrc_out_stage
	import mrc_pkg::*;
#(
	parameter  int LEN_W   = 7,
	localparam int TDATA_W = ((LEN_LSB + LEN_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  res_t               res,
	input  logic [LEN_W-1:0]   res_len,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tuser
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tuser <= res.kind;
			m_tdata <= TDATA_W'({res_len, res.exception_code, res.status, res.payload_byte});
		end
	end

endmodule

@@ rtl/mrc_checker.sv @@
// Port-level assertions for the Modbus RTU response checker, bound to the top level.
// Depends on mrc_pkg and modbus_rtu_response_checker_macros.svh.
`include "modbus_rtu_response_checker_macros.svh"

module mrc_checker
	import mrc_pkg::*;
#(
	parameter int TDATA_W = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tuser
);

	logic [2:0] st;

	assign st = m_tdata[ST_LSB+2:ST_LSB];

	`MRC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`MRC_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`MRC_ASSERT_IMPLY(a_pay_clean, m_tvalid && !m_tuser, m_tdata[TDATA_W-1:ST_LSB] == '0, "payload request carries status fields")
	`MRC_ASSERT_IMPLY(a_st_range, m_tvalid && m_tuser, st <= ST_EXCEPTION, "status code out of range")
	`MRC_ASSERT_IMPLY(a_len_ok, m_tvalid && m_tuser && st != ST_OK, m_tdata[TDATA_W-1:LEN_LSB] == '0, "frame length on failed frame")

endmodule

bind modbus_rtu_response_checker mrc_checker #(.TDATA_W(TDATA_W)) u_mrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
